FILE: rtl/assert_macros.svh
// Assertion helpers, included by the frame checker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/crc8lfc_pkg.sv
`default_nettype none

package crc8lfc_pkg;

  // Register reset values
  localparam logic [7:0] CRC_POLY_RESET = 8'h07;
  localparam logic [7:0] CRC_INIT_RESET = 8'h00;
  localparam logic [8:0] MAX_LEN_RESET  = 9'd130;

  localparam logic [7:0] CRC_MSB = 8'h80;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_POLY    = 2'd0,
    REG_INIT    = 2'd1,
    REG_MAX_LEN = 2'd2
  } reg_idx_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PASS    = 2'd0,
    ST_FAIL    = 2'd1,
    ST_BAD_LEN = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] poly;
    logic [7:0] init;
    logic [8:0] max_len;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  data_length;
    logic [7:0]  computed_crc;
    logic [7:0]  received_crc;
    logic [31:0] frames_checked;
    logic [31:0] frames_passed;
    logic [31:0] frames_failed;
  } result_t;

  // One byte of MSB-first CRC-8, all eight shift steps unrolled
  function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = (c << 1) ^ poly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/crc8_length_frame_checker.sv
// Length-prefixed CRC-8 frame checker.
// Input stream (s_axis): one request per received byte or timeout tick.
//   tuser carries the command (0 = byte, 1 = timeout), tdata the byte.
//   A stream of [LENGTH][DATA...][CRC8] frames is checked with a running
//   MSB-first CRC-8 over the length and data bytes.
// Output stream (m_axis): one request per finished frame (pass or fail)
//   and per rejected length byte; data bytes and ticks give none.
// Configuration goes through the APB port: polynomial at 0x0, initial
//   value at 0x4, largest total frame length at 0x8; write only while idle.
// Pipeline: two register stages; an accepted byte is held in the input
//   register, and the state update then loads the result register, from
//   which the result is presented on m_axis.
// Throughput: one request per cycle while m_axis is not stalled; the
//   CRC update and final compare are combinational between the registers.
// Reset clears the frame state, the counters and the valid flags of both
//   stream registers and loads the register defaults (0x07, 0x00, 130).
// When the receiver holds m_axis_tready low the result register holds its
//   request, one more input byte is taken into the input register, and
//   s_axis_tready then drops until the stall clears.
`default_nettype none

`include "assert_macros.svh"

module crc8_length_frame_checker
  import crc8lfc_pkg::*;
#(
  parameter int COUNTER_WIDTH = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  input  wire logic         s_axis_tuser,   // [0] command
  // output stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [7:0] data_length, [15:8] computed_crc, [23:16] received_crc,
  // [55:24] frames_checked, [87:56] frames_passed, [119:88] frames_failed
  output logic [119:0]      m_axis_tdata,
  output logic [1:0]        m_axis_tuser,   // [1:0] status
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);

  cfg_t       cfg;
  logic       in_valid_q;
  logic       in_cmd_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q;
  result_t    res_q;

  crc8lfc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Item moves on when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  crc8lfc_frame_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_frame_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .cmd_i       (in_cmd_q),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {res_q.frames_failed, res_q.frames_passed,
                          res_q.frames_checked, res_q.received_crc,
                          res_q.computed_crc, res_q.data_length};

  // Checks
  `ASSERT_ALWAYS(a_pass_crc_eq, clk_i, rst_ni, !(out_valid_q && res_q.status == ST_PASS) || (res_q.computed_crc == res_q.received_crc), "pass result with differing CRCs")
  `ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !advance, in_valid_q && $stable(in_byte_q) && $stable(in_cmd_q), "stalled input request lost or changed")
  `ASSERT_NEXT(a_out_source, clk_i, rst_ni, !out_valid_q && !advance, !out_valid_q, "result without an advancing request")

endmodule

`default_nettype wire

FILE: rtl/crc8lfc_cfg_regs.sv
`default_nettype none

module crc8lfc_cfg_regs
  import crc8lfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [7:0] poly_q, poly_d;
  logic [7:0] init_q, init_d;
  logic [8:0] max_len_q, max_len_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Write decode
  always_comb begin
    poly_d    = poly_q;
    init_d    = init_q;
    max_len_d = max_len_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_POLY:    poly_d    = pwdata[7:0];
        REG_INIT:    init_d    = pwdata[7:0];
        REG_MAX_LEN: max_len_d = pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q    <= CRC_POLY_RESET;
      init_q    <= CRC_INIT_RESET;
      max_len_q <= MAX_LEN_RESET;
    end else begin
      poly_q    <= poly_d;
      init_q    <= init_d;
      max_len_q <= max_len_d;
    end
  end

  // Read decode
  always_comb begin
    unique case (reg_idx)
      REG_POLY:    prdata = {24'd0, poly_q};
      REG_INIT:    prdata = {24'd0, init_q};
      REG_MAX_LEN: prdata = {23'd0, max_len_q};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{poly: poly_q, init: init_q, max_len: max_len_q};

endmodule

`default_nettype wire

FILE: rtl/crc8lfc_frame_core.sv
`default_nettype none

module crc8lfc_frame_core
  import crc8lfc_pkg::*;
#(
  parameter int COUNTER_WIDTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic       cmd_i,
  input  wire logic [7:0] byte_i,
  input  wire cfg_t       cfg_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  logic [8:0]               pos_q, pos_d;
  logic [8:0]               exp_q, exp_d;
  logic [7:0]               len_q, len_d;
  logic [7:0]               crc_q, crc_d;
  logic [COUNTER_WIDTH-1:0] chk_q, chk_d;
  logic [COUNTER_WIDTH-1:0] pas_q, pas_d;
  logic [COUNTER_WIDTH-1:0] fal_q, fal_d;

  logic [8:0]  total;
  logic [8:0]  pos_inc;
  logic        crc_match;
  logic [7:0]  crc_base;
  logic [7:0]  crc_next;

  assign total     = {1'b0, byte_i} + 9'd2;
  assign pos_inc   = pos_q + 9'd1;
  assign crc_match = (crc_q == byte_i);
  // A length byte restarts from the initial value, a data byte continues
  assign crc_base  = (exp_q == 9'd0) ? cfg_i.init : crc_q;
  assign crc_next  = crc8_update(crc_base, byte_i, cfg_i.poly);

  // Frame state update and result forming
  always_comb begin
    pos_d       = pos_q;
    exp_d       = exp_q;
    len_d       = len_q;
    crc_d       = crc_q;
    chk_d       = chk_q;
    pas_d       = pas_q;
    fal_d       = fal_q;
    res_valid_o = 1'b0;
    res_o.status       = ST_PASS;
    res_o.data_length  = len_q;
    res_o.computed_crc = crc_q;
    res_o.received_crc = byte_i;
    if (fire_i) begin
      if (cmd_i) begin
        // timeout: drop any partial frame
        pos_d = 9'd0;
        exp_d = 9'd0;
      end else if (exp_q == 9'd0) begin
        if (byte_i == 8'd0 || total > cfg_i.max_len) begin
          pos_d              = 9'd0;
          res_valid_o        = 1'b1;
          res_o.status       = ST_BAD_LEN;
          res_o.data_length  = byte_i;
          res_o.computed_crc = 8'd0;
          res_o.received_crc = 8'd0;
        end else begin
          exp_d = total;
          len_d = byte_i;
          pos_d = 9'd1;
          crc_d = crc_next;
        end
      end else if (pos_inc >= exp_q) begin
        // final byte: the transmitted CRC
        pos_d       = 9'd0;
        exp_d       = 9'd0;
        chk_d       = chk_q + 1'b1;
        res_valid_o = 1'b1;
        if (crc_match) begin
          pas_d        = pas_q + 1'b1;
          res_o.status = ST_PASS;
        end else begin
          fal_d        = fal_q + 1'b1;
          res_o.status = ST_FAIL;
        end
      end else begin
        pos_d = pos_inc;
        crc_d = crc_next;
      end
    end
    // Counters shown as their low 32 bits, zero extended when narrower
    res_o.frames_checked = 32'(chk_d);
    res_o.frames_passed  = 32'(pas_d);
    res_o.frames_failed  = 32'(fal_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      exp_q <= '0;
      len_q <= '0;
      crc_q <= '0;
      chk_q <= '0;
      pas_q <= '0;
      fal_q <= '0;
    end else begin
      pos_q <= pos_d;
      exp_q <= exp_d;
      len_q <= len_d;
      crc_q <= crc_d;
      chk_q <= chk_d;
      pas_q <= pas_d;
      fal_q <= fal_d;
    end
  end

endmodule

`default_nettype wire
